// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the pixel map core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define BDP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define BDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bdp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdp_pkg
// types and constants shared by the box decimation pixel map core
// ----------------------------------------------------------------------------
package bdp_pkg;

  localparam int MAX_SPR     = 2048;
  localparam int MAX_ROWS    = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = 25;
  localparam int COL_W       = 11;
  localparam int ROW_W       = 12;

  // 20*log10(2)*16 in q16
  localparam logic [23:0] DB_PER_OCTAVE_Q16 = 24'd6313057;

  // register indexes
  localparam logic [2:0] REG_SPR   = 3'd0;
  localparam logic [2:0] REG_RPF   = 3'd1;
  localparam logic [2:0] REG_BF    = 3'd2;
  localparam logic [2:0] REG_MIN   = 3'd3;
  localparam logic [2:0] REG_RANGE = 3'd4;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [12:0]        spr;
    logic [12:0]        rpf;
    logic [4:0]         bf;
    logic signed [11:0] min_level;
    logic [11:0]        range;
  } cfg_eff_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic [COL_W-1:0]              col;
    logic                          first;
    logic                          emit;
    logic [COL_W-1:0]              out_column;
    logic [ROW_W-1:0]              out_row;
    logic                          frame_done;
  } mid_entry_t;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_done;
  } result_t;

  typedef enum logic [0:0] {
    FS_CALC,
    FS_RUN
  } front_state_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SQ_RE,
    BS_SQ_IM,
    BS_SQRT,
    BS_ACC,
    BS_LNORM,
    BS_LSQ,
    BS_SCALE,
    BS_DIFF,
    BS_TRIM,
    BS_DIV,
    BS_OUT
  } back_state_t;

endpackage

// ===== rtl/core/bdp_ram.sv =====
// ----------------------------------------------------------------------------
// bdp_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
module bdp_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// ===== rtl/core/bdp_fifo.sv =====
// ----------------------------------------------------------------------------
// bdp_fifo
// small register queue, depth two or more
// ----------------------------------------------------------------------------
module bdp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bdp_front.sv =====
// ----------------------------------------------------------------------------
// bdp_front
// sample counters, box position tracking and item classification
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdp_pkg::cfg_eff_t             cfg,
  input  logic                          cfg_wr,
  input  logic                          item_valid,
  input  logic signed [15:0]            sample_re,
  input  logic signed [15:0]            sample_im,
  input  logic                          right_to_left,
  output logic                          ready,
  output logic                          mid_push,
  output bdp_pkg::mid_entry_t           mid_entry
);

  bdp_pkg::front_state_t state_r, state_nxt;

  // shared serial divider by the box size
  logic [1:0]  sel_r;
  logic [3:0]  cnt_r;
  logic [12:0] num_r, quo_r;
  logic [3:0]  rem_r;
  logic [12:0] numer, num_cur, quo_cur, q_n;
  logic [3:0]  rem_cur, rem_n;
  logic [4:0]  t_div;
  logic        div_last;

  logic [11:0] width_r;
  logic        band_ok_r;
  logic [12:0] last_band_row_r;
  logic [10:0] k_r, col_r;
  logic [3:0]  pos_r, rib_r, rmod_r;
  logic [11:0] row_index_r, rq_r;

  logic        col_ok, first, last_row, emit, fdone, k_last, row_last;
  logic [11:0] width_m1;
  logic [10:0] oc;

  always_comb begin
    unique case (sel_r)
      2'd0:    numer = cfg.spr;
      2'd1:    numer = cfg.rpf;
      2'd2:    numer = {2'b0, k_r};
      default: numer = {1'b0, row_index_r};
    endcase
    num_cur = (cnt_r == '0) ? numer : num_r;
    quo_cur = (cnt_r == '0) ? '0 : quo_r;
    rem_cur = (cnt_r == '0) ? '0 : rem_r;
    t_div   = {rem_cur, num_cur[12]};
    if (t_div >= cfg.bf) begin
      rem_n = 4'(t_div - cfg.bf);
      q_n   = {quo_cur[11:0], 1'b1};
    end else begin
      rem_n = t_div[3:0];
      q_n   = {quo_cur[11:0], 1'b0};
    end
    div_last = (cnt_r == 4'd12);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      state_nxt = bdp_pkg::FS_CALC;
    end else if (state_r == bdp_pkg::FS_CALC && div_last && sel_r == 2'd3) begin
      state_nxt = bdp_pkg::FS_RUN;
    end
  end

  // outputs
  always_comb begin
    ready    = (state_r == bdp_pkg::FS_RUN);
    col_ok   = ({1'b0, col_r} < width_r);
    first    = (rib_r == '0) && (pos_r == '0);
    last_row = ({1'b0, rib_r} >= cfg.bf - 5'd1);
    emit     = last_row && ({1'b0, pos_r} == cfg.bf - 5'd1);
    width_m1 = width_r - 12'd1;
    oc       = right_to_left ? 11'(width_m1 - {1'b0, col_r}) : col_r;
    fdone    = band_ok_r && ({1'b0, row_index_r} == last_band_row_r) &&
               ({1'b0, col_r} == width_m1);
    k_last   = ({2'b0, k_r} + 13'd1 >= cfg.spr);
    row_last = ({1'b0, row_index_r} + 13'd1 >= cfg.rpf);

    mid_push              = item_valid && col_ok;
    mid_entry.re          = sample_re;
    mid_entry.im          = sample_im;
    mid_entry.col         = col_r;
    mid_entry.first       = first;
    mid_entry.emit        = emit;
    mid_entry.out_column  = oc;
    mid_entry.out_row     = rq_r;
    mid_entry.frame_done  = fdone;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdp_pkg::FS_CALC;
      sel_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      row_index_r <= '0;
      rib_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        sel_r <= '0;
        cnt_r <= '0;
      end else if (state_r == bdp_pkg::FS_CALC) begin
        num_r <= {num_cur[11:0], 1'b0};
        quo_r <= q_n;
        rem_r <= rem_n;
        if (div_last) begin
          cnt_r <= '0;
          sel_r <= sel_r + 2'd1;
          unique case (sel_r)
            2'd0: width_r <= q_n[11:0];
            2'd1: begin
              band_ok_r       <= (q_n != '0);
              last_band_row_r <= cfg.rpf - {9'b0, rem_n} - 13'd1;
            end
            2'd2: begin
              col_r <= q_n[10:0];
              pos_r <= rem_n;
            end
            default: begin
              rq_r   <= q_n[11:0];
              rmod_r <= rem_n;
            end
          endcase
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end else if (item_valid) begin
        if (k_last) begin
          k_r   <= '0;
          col_r <= '0;
          pos_r <= '0;
          if (row_last) begin
            row_index_r <= '0;
            rib_r       <= '0;
            rmod_r      <= '0;
            rq_r        <= '0;
          end else begin
            row_index_r <= row_index_r + 12'd1;
            rib_r       <= last_row ? 4'd0 : rib_r + 4'd1;
            if ({1'b0, rmod_r} + 5'd1 >= cfg.bf) begin
              rmod_r <= '0;
              rq_r   <= rq_r + 12'd1;
            end else begin
              rmod_r <= rmod_r + 4'd1;
            end
          end
        end else begin
          k_r <= k_r + 11'd1;
          if ({1'b0, pos_r} + 5'd1 >= cfg.bf) begin
            pos_r <= '0;
            col_r <= col_r + 11'd1;
          end else begin
            pos_r <= pos_r + 4'd1;
          end
        end
      end
    end
  end

  `BDP_ASSERT(a_pos_in_box, clk, rst_n, (state_r == bdp_pkg::FS_RUN) |-> ({1'b0, pos_r} < cfg.bf), "column position beyond box size")
  `BDP_ASSERT(a_rmod_in_box, clk, rst_n, (state_r == bdp_pkg::FS_RUN) |-> ({1'b0, rmod_r} < cfg.bf), "row remainder beyond box size")

endmodule

// ===== rtl/core/bdp_back.sv =====
// ----------------------------------------------------------------------------
// bdp_back
// magnitude, column sum update and log scaling to a display pixel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bdp_pkg::cfg_eff_t   cfg,
  input  logic                mid_empty,
  input  bdp_pkg::mid_entry_t mid_entry,
  output logic                mid_pop,
  input  logic                out_full,
  output logic                out_push,
  output bdp_pkg::result_t    out_item,
  output logic                clearing
);

  localparam int AW = $clog2(bdp_pkg::MAX_SPR);

  bdp_pkg::back_state_t state_r, state_nxt;
  bdp_pkg::mid_entry_t  ent_r;

  logic [AW-1:0]      clr_addr_r;
  logic [31:0]        x_r, r_r, bit_r;
  logic [3:0]         cnt_r;
  logic [30:0]        m_r;
  logic [4:0]         e_r;
  logic [15:0]        res_r;
  logic               lsel_r;
  logic [20:0]        logs_r, lb_r;
  logic signed [46:0] prod_r;
  logic signed [47:0] diff_r;
  logic [22:0]        t_r;
  logic [8:0]         q_r;
  logic [7:0]         pix_r;

  logic signed [15:0] sq_op;
  logic signed [31:0] sq_full;
  logic [31:0]        rb;
  logic [25:0]        sum_raw;
  logic [24:0]        sum_sat;
  logic [24:0]        rd_data;
  logic [61:0]        msq;
  logic [31:0]        mt;
  logic [15:0]        res_n;
  logic signed [21:0] lval;
  logic [55:0]        d56, d255;
  logic [20:0]        dvs;
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [24:0]        ram_wd;
  logic               sqrt_done, lsq_done, clr_done;

  bdp_ram #(
    .WIDTH(bdp_pkg::SUM_W),
    .DEPTH(bdp_pkg::MAX_SPR)
  ) u_sums (
    .clk      (clk),
    .wr_en    (ram_we),
    .wr_addr  (ram_wa),
    .wr_data  (ram_wd),
    .rd_addr  (ent_r.col),
    .rd_data_r(rd_data)
  );

  // datapath terms
  always_comb begin
    sq_op   = (state_r == bdp_pkg::BS_SQ_RE) ? ent_r.re : ent_r.im;
    sq_full = sq_op * sq_op;
    rb      = r_r + bit_r;
    sum_raw = ent_r.first ? {10'b0, r_r[15:0]} : {1'b0, rd_data} + {10'b0, r_r[15:0]};
    sum_sat = sum_raw[25] ? '1 : sum_raw[24:0];
    msq     = {31'b0, m_r} * {31'b0, m_r};
    mt      = msq[61:30];
    res_n   = {res_r[14:0], mt[31]};
    lval    = $signed({1'b0, logs_r}) - $signed({1'b0, lb_r});
    d56     = {8'b0, diff_r};
    d255    = {d56[47:0], 8'b0} - d56;
    dvs     = {9'b0, cfg.range} << cnt_r;
    sqrt_done = (cnt_r == 4'd15);
    lsq_done  = (cnt_r == 4'd15);
    clr_done  = (clr_addr_r == AW'(bdp_pkg::MAX_SPR - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdp_pkg::BS_CLEAR: if (clr_done) state_nxt = bdp_pkg::BS_IDLE;
      bdp_pkg::BS_IDLE:  if (!mid_empty) state_nxt = bdp_pkg::BS_SQ_RE;
      bdp_pkg::BS_SQ_RE: state_nxt = bdp_pkg::BS_SQ_IM;
      bdp_pkg::BS_SQ_IM: state_nxt = bdp_pkg::BS_SQRT;
      bdp_pkg::BS_SQRT:  if (sqrt_done) state_nxt = bdp_pkg::BS_ACC;
      bdp_pkg::BS_ACC: begin
        priority if (!ent_r.emit)    state_nxt = bdp_pkg::BS_IDLE;
        else if (sum_sat == '0)      state_nxt = bdp_pkg::BS_OUT;
        else                         state_nxt = bdp_pkg::BS_LNORM;
      end
      bdp_pkg::BS_LNORM: if (m_r[30]) state_nxt = bdp_pkg::BS_LSQ;
      bdp_pkg::BS_LSQ: begin
        if (lsq_done) state_nxt = lsel_r ? bdp_pkg::BS_SCALE : bdp_pkg::BS_LNORM;
      end
      bdp_pkg::BS_SCALE: state_nxt = bdp_pkg::BS_DIFF;
      bdp_pkg::BS_DIFF:  state_nxt = bdp_pkg::BS_TRIM;
      bdp_pkg::BS_TRIM: begin
        priority if (diff_r[47] || diff_r == '0) state_nxt = bdp_pkg::BS_OUT;
        else if (cfg.range == '0)               state_nxt = bdp_pkg::BS_OUT;
        else                                    state_nxt = bdp_pkg::BS_DIV;
      end
      bdp_pkg::BS_DIV: begin
        if (cnt_r == 4'd9) begin
          if (t_r >= {2'b0, cfg.range, 9'b0}) state_nxt = bdp_pkg::BS_OUT;
        end else if (cnt_r == 4'd0) begin
          state_nxt = bdp_pkg::BS_OUT;
        end
      end
      bdp_pkg::BS_OUT:   if (!out_full) state_nxt = bdp_pkg::BS_IDLE;
      default:           state_nxt = bdp_pkg::BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    clearing            = (state_r == bdp_pkg::BS_CLEAR);
    mid_pop             = (state_r == bdp_pkg::BS_IDLE) && !mid_empty;
    out_push            = (state_r == bdp_pkg::BS_OUT) && !out_full;
    ram_we              = clearing || (state_r == bdp_pkg::BS_ACC);
    ram_wa              = clearing ? clr_addr_r : ent_r.col;
    ram_wd              = clearing ? '0 : sum_sat;
    out_item.pixel      = pix_r;
    out_item.out_column = ent_r.out_column;
    out_item.out_row    = ent_r.out_row;
    out_item.frame_done = ent_r.frame_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bdp_pkg::BS_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bdp_pkg::BS_IDLE: begin
        if (!mid_empty) ent_r <= mid_entry;
      end
      bdp_pkg::BS_SQ_RE: x_r <= 32'(sq_full);
      bdp_pkg::BS_SQ_IM: begin
        x_r   <= x_r + 32'(sq_full);
        r_r   <= '0;
        bit_r <= 32'h4000_0000;
        cnt_r <= '0;
      end
      bdp_pkg::BS_SQRT: begin
        if (x_r >= rb) begin
          x_r <= x_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 4'd1;
      end
      bdp_pkg::BS_ACC: begin
        pix_r  <= '0;
        m_r    <= {6'b0, sum_sat};
        e_r    <= 5'd30;
        lsel_r <= 1'b0;
      end
      bdp_pkg::BS_LNORM: begin
        if (m_r[30]) begin
          cnt_r <= '0;
          res_r <= '0;
        end else begin
          m_r <= {m_r[29:0], 1'b0};
          e_r <= e_r - 5'd1;
        end
      end
      bdp_pkg::BS_LSQ: begin
        res_r <= res_n;
        m_r   <= mt[31] ? mt[31:1] : mt[30:0];
        cnt_r <= cnt_r + 4'd1;
        if (lsq_done) begin
          if (lsel_r) begin
            lb_r <= {e_r, res_n};
          end else begin
            logs_r <= {e_r, res_n};
            m_r    <= {21'b0, 10'(cfg.bf) * 10'(cfg.bf)};
            e_r    <= 5'd30;
            lsel_r <= 1'b1;
          end
        end
      end
      bdp_pkg::BS_SCALE: prod_r <= 47'(lval * $signed({1'b0, bdp_pkg::DB_PER_OCTAVE_Q16}));
      bdp_pkg::BS_DIFF: begin
        diff_r <= 48'(prod_r) - $signed({{4{cfg.min_level[11]}}, cfg.min_level, 32'b0});
      end
      bdp_pkg::BS_TRIM: begin
        pix_r <= (diff_r[47] || diff_r == '0) ? 8'd0 : 8'd255;
        t_r   <= d255[54:32];
        cnt_r <= 4'd9;
        q_r   <= '0;
      end
      bdp_pkg::BS_DIV: begin
        if (cnt_r == 4'd9) begin
          cnt_r <= 4'd8;
        end else begin
          if ({2'b0, t_r} >= {4'b0, dvs}) begin
            t_r <= 23'({2'b0, t_r} - {4'b0, dvs});
            q_r[cnt_r] <= 1'b1;
            if (cnt_r == 4'd0) pix_r <= (q_r[8] || cnt_r == 4'd8) ? 8'd255 : {q_r[7:1], 1'b1};
          end else if (cnt_r == 4'd0) begin
            pix_r <= q_r[8] ? 8'd255 : {q_r[7:1], 1'b0};
          end
          cnt_r <= cnt_r - 4'd1;
        end
      end
      default: ;
    endcase
  end

  `BDP_ASSERT(a_push_only_emit, clk, rst_n, out_push |-> ent_r.emit, "result pushed for an item that closes no box")
  `BDP_ASSERT(a_log_normalized, clk, rst_n, (state_r == bdp_pkg::BS_LSQ) |-> m_r[30], "log mantissa not normalized")
  `BDP_ASSERT(a_mag_fits, clk, rst_n, (state_r == bdp_pkg::BS_SQRT && sqrt_done) |=> (r_r[31:16] == '0), "magnitude wider than 16 bits")
  `BDP_ASSERT(a_no_pop_clear, clk, rst_n, clearing |-> !mid_pop && !out_push, "work started during clearing pass")

endmodule

// ===== rtl/core/box_decimate_db_pixel_map_core.sv =====
// ----------------------------------------------------------------------------
// box_decimate_db_pixel_map_core
// box-sum decimation of complex samples with log compression to 8-bit pixels
// ----------------------------------------------------------------------------
//  channel | ports                                   | accepted when
//  --------+-----------------------------------------+----------------------
//  input   | in_push in_full in_sample_* in_right_.. | push & !full
//  result  | out_empty out_pop out_pixel out_column  | pop & !empty
//          | out_row out_frame_done                  |
//  config  | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite
//
//  after reset the column sum memory is swept to zero, in_full high
//  a config write restarts the box position recompute, in_full high
//  an item that closes no box goes through two squares, 16 root steps and the sum
//  update in the back end; a pixel item with a nonzero sum adds two serial log2
//  runs (up to 30 normalize steps plus 16 squarings each), scale and up to 10
//  divide steps; the back end works one item at a time
//  items outside the last full box column are taken by the front and not passed on
//  two-entry queues sit between front and back and in front of the result port
// ----------------------------------------------------------------------------
module box_decimate_db_pixel_map_core (
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  input  logic               in_right_to_left,
  // result item channel
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_pixel,
  output logic [10:0]        out_column,
  output logic [11:0]        out_row,
  output logic               out_frame_done,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // raw registers, samples per row one bit wider than its written field
  logic [12:0] spr_r;
  logic [12:0] rpf_r;
  logic [4:0]  bf_r;
  logic [11:0] min_r;
  logic [11:0] range_r;

  logic [2:0]          reg_idx;
  logic                cfg_wr;
  bdp_pkg::cfg_eff_t   cfg;

  logic                front_ready, item_valid, clearing;
  logic                mid_push, mid_full, mid_pop, mid_empty;
  bdp_pkg::mid_entry_t mid_in, mid_out;
  logic                res_push, res_full;
  bdp_pkg::result_t    res_in, res_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r   <= 13'd2048;
      rpf_r   <= 13'd4096;
      bf_r    <= 5'd4;
      min_r   <= 12'd960;
      range_r <= 12'd1600;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bdp_pkg::REG_SPR:   spr_r   <= {1'b0, pwdata[11:0]};
        bdp_pkg::REG_RPF:   rpf_r   <= pwdata[12:0];
        bdp_pkg::REG_BF:    bf_r    <= pwdata[4:0];
        bdp_pkg::REG_MIN:   min_r   <= pwdata[11:0];
        bdp_pkg::REG_RANGE: range_r <= pwdata[11:0];
        default: ;  // beyond the register list, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdp_pkg::REG_SPR:   prdata = {19'b0, spr_r};
      bdp_pkg::REG_RPF:   prdata = {19'b0, rpf_r};
      bdp_pkg::REG_BF:    prdata = {27'b0, bf_r};
      bdp_pkg::REG_MIN:   prdata = {20'b0, min_r};
      bdp_pkg::REG_RANGE: prdata = {20'b0, range_r};
      default:            prdata = '0;
    endcase
  end

  // clamp lengths and box size to their usable range
  always_comb begin
    priority if (spr_r == '0)                  cfg.spr = 13'd1;
    else if (spr_r > 13'(bdp_pkg::MAX_SPR))    cfg.spr = 13'(bdp_pkg::MAX_SPR);
    else                                       cfg.spr = spr_r;
    priority if (rpf_r == '0)                  cfg.rpf = 13'd1;
    else if (rpf_r > 13'(bdp_pkg::MAX_ROWS))   cfg.rpf = 13'(bdp_pkg::MAX_ROWS);
    else                                       cfg.rpf = rpf_r;
    priority if (bf_r == '0)                   cfg.bf = 5'd1;
    else if (bf_r > 5'd16)                     cfg.bf = 5'd16;
    else                                       cfg.bf = bf_r;
    cfg.min_level = $signed(min_r);
    cfg.range     = range_r;
  end

  // no item taken while recomputing positions or sweeping the sum memory
  assign in_full    = ~front_ready | mid_full | clearing;
  assign item_valid = in_push & ~in_full;

  bdp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cfg_wr       (cfg_wr),
    .item_valid   (item_valid),
    .sample_re    (in_sample_re),
    .sample_im    (in_sample_im),
    .right_to_left(in_right_to_left),
    .ready        (front_ready),
    .mid_push     (mid_push),
    .mid_entry    (mid_in)
  );

  // classified items waiting for the back end
  bdp_fifo #(
    .WIDTH($bits(bdp_pkg::mid_entry_t)),
    .DEPTH(2)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .din  (mid_in),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_out),
    .empty(mid_empty)
  );

  bdp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mid_empty(mid_empty),
    .mid_entry(mid_out),
    .mid_pop  (mid_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_in),
    .clearing (clearing)
  );

  // finished pixels, parts the back end from the consumer
  bdp_fifo #(
    .WIDTH($bits(bdp_pkg::result_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_out),
    .empty(out_empty)
  );

  assign out_pixel      = res_out.pixel;
  assign out_column     = res_out.out_column;
  assign out_row        = res_out.out_row;
  assign out_frame_done = res_out.frame_done;

endmodule

// ===== tb/sv/box_decimate_db_pixel_map_core_tb.sv =====
// ----------------------------------------------------------------------------
// box_decimate_db_pixel_map_core_tb
// self-checking bench for the box decimation pixel map core: a cycle-free
// predictor of box sums and dB pixels runs on every accepted sample, and each
// popped pixel is compared field by field with the oldest predicted pixel
// ----------------------------------------------------------------------------
module box_decimate_db_pixel_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdp_pkg::*;

  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          SETTLE      = 300;   // back end drain, one slow pixel and more
  localparam longint      DB_OCT      = 64'sd6313057;
  localparam logic [24:0] SUM_SAT     = 25'h1FF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_sample_re;
  logic signed [15:0] in_sample_im;
  logic               in_right_to_left;
  logic               out_empty;
  logic               out_pop;
  logic [7:0]         out_pixel;
  logic [10:0]        out_column;
  logic [11:0]        out_row;
  logic               out_frame_done;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  box_decimate_db_pixel_map_core u_dut (.*);

  // ---------------------------------------------------------------------------
  // predictor state: register copies, box sums and counters
  // ---------------------------------------------------------------------------
  logic [12:0]        r_spr;
  logic [12:0]        r_rpf;
  logic [4:0]         r_bf;
  logic signed [11:0] r_min;
  logic [11:0]        r_range;

  logic [24:0] box_sum [MAX_SPR];
  int unsigned smp_idx, band_row, frame_row;

  result_t pixel_q[$];   // predicted pixels, oldest first
  int      errors;
  int      cycles;

  // sender pacing
  int burst_left;
  bit no_gaps;
  // receiver hold-off request, bumped by a test, served by the pop process
  int hold_tag;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // fixed point math of the pixel mapping
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  // log2 in q16, x >= 1
  function automatic longint log2_fix(input logic [31:0] x);
    int unsigned     e;
    longint unsigned m, res;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = longint'(x) << (30 - e);
    res = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      res <<= 1;
      if (m >= (64'd1 << 31)) begin
        res |= 1;
        m >>= 1;
      end
    end
    return longint'((longint'(e) << 16) | res);
  endfunction

  function automatic logic [7:0] db_pixel(input logic [24:0] sum, input int unsigned b);
    longint          lvl, diff;
    longint unsigned num, den, q;
    if (sum == 0) return 8'd0;
    lvl  = log2_fix(32'(sum)) - log2_fix(32'(b * b));
    diff = lvl * DB_OCT - longint'(r_min) * 64'sd4294967296;
    if (diff <= 0) return 8'd0;
    if (r_range == 0) return 8'd255;
    num = longint'(diff) * 255;
    den = longint'(r_range) << 32;
    q   = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // one accepted sample: update sums and counters, queue a pixel if a box closes
  function automatic void predict_sample(input logic signed [15:0] re,
                                         input logic signed [15:0] im,
                                         input logic rtl);
    int unsigned     spr, rpf, b, width, col, pos, nb;
    bit              first_row, last_row;
    longint          re_l, im_l;
    longint unsigned s;
    result_t         px;
    spr = (r_spr == 0) ? 1 : ((r_spr > MAX_SPR) ? MAX_SPR : r_spr);
    rpf = (r_rpf == 0) ? 1 : ((r_rpf > MAX_ROWS) ? MAX_ROWS : r_rpf);
    b   = (r_bf == 0) ? 1 : ((r_bf > 16) ? 16 : r_bf);
    width     = spr / b;
    col       = smp_idx / b;
    pos       = smp_idx % b;
    first_row = (band_row == 0);
    last_row  = (band_row >= b - 1);
    if (col < width) begin
      re_l = re;
      im_l = im;
      s = int_sqrt(longint'(re_l * re_l + im_l * im_l));
      if (!(first_row && pos == 0)) s += box_sum[col];
      if (s > SUM_SAT) s = SUM_SAT;
      box_sum[col] = s[24:0];
      if (last_row && pos == b - 1) begin
        nb = rpf / b;
        px.pixel      = db_pixel(s[24:0], b);
        px.out_column = rtl ? COL_W'(width - 1 - col) : COL_W'(col);
        px.out_row    = ROW_W'(frame_row / b);
        px.frame_done = (nb > 0 && frame_row == nb * b - 1 && col == width - 1);
        pixel_q.push_back(px);
      end
    end
    if (smp_idx + 1 >= spr) begin
      smp_idx = 0;
      if (frame_row + 1 >= rpf) begin
        frame_row = 0;
        band_row  = 0;
      end else begin
        frame_row++;
        band_row = last_row ? 0 : band_row + 1;
      end
    end else begin
      smp_idx++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: pop pattern, long hold-off, and the pixel checker
  // ---------------------------------------------------------------------------
  initial begin : pop_pattern
    int mode, left, hold_left, seen_tag;
    mode = 0;
    left = 0;
    hold_left = 0;
    seen_tag = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tag != seen_tag) begin
        seen_tag  = hold_tag;
        hold_left = 800;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (mode)
          0: out_pop <= 1'b1;                          // always ready
          1: out_pop <= $urandom_range(0, 1);
          2: out_pop <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t px;
    if (rst_n && out_pop && !out_empty) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel item px=%0d col=%0d row=%0d fd=%0d", $time,
                 out_pixel, out_column, out_row, out_frame_done);
        errors++;
      end else begin
        px = pixel_q.pop_front();
        if (out_pixel !== px.pixel) begin
          $display("%0t: pixel expected %0d actual %0d", $time, px.pixel, out_pixel);
          errors++;
        end
        if (out_column !== px.out_column) begin
          $display("%0t: column expected %0d actual %0d", $time, px.out_column, out_column);
          errors++;
        end
        if (out_row !== px.out_row) begin
          $display("%0t: row expected %0d actual %0d", $time, px.out_row, out_row);
          errors++;
        end
        if (out_frame_done !== px.frame_done) begin
          $display("%0t: frame_done expected %0d actual %0d", $time, px.frame_done,
                   out_frame_done);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // offer one sample and hold it until the core takes it
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic rtl);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_push          <= 1'b1;
    in_sample_re     <= re;
    in_sample_im     <= im;
    in_right_to_left <= rtl;
    do @(posedge clk); while (in_full);
    predict_sample(re, im, rtl);
  endtask

  // stop offering, let every pixel drain and the back end go quiet
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    wait (pixel_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup and access phase register write; only called with the core idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPR:   r_spr   = {1'b0, val[11:0]};
      REG_RPF:   r_rpf   = val[12:0];
      REG_BF:    r_bf    = val[4:0];
      REG_MIN:   r_min   = val[11:0];
      REG_RANGE: r_range = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int spr, input int rpf, input int bf, input int mn,
                            input int rng);
    drain();
    write_reg(REG_SPR, 32'(spr));
    write_reg(REG_RPF, 32'(rpf));
    write_reg(REG_BF, 32'(bf));
    write_reg(REG_MIN, 32'(mn));
    write_reg(REG_RANGE, 32'(rng));
  endtask

  // random sample: mostly magnitudes spread over all octaves, some full range
  function automatic logic signed [15:0] rand_part();
    int sh;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    sh = $urandom_range(0, 15);
    return 16'($urandom_range(0, (1 << sh) - 1)) * ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // extremes of every field, trailing column and partial band at frame end
  task automatic test_extremes();
    logic signed [15:0] vals [6];
    vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555};
    set_config(5, 5, 2, -2048, 16);  // width 2 with one trailing sample, row 4 partial
    for (int i = 0; i < 25; i++)
      send_sample(vals[i % 6], vals[(i * 5 + 1) % 6], i[1]);
  endtask

  // odd box, top of the level range, zero sum
  task automatic test_odd_box();
    set_config(6, 6, 3, 2047, 4095);
    for (int i = 0; i < 18; i++) send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    for (int i = 0; i < 18; i++) send_sample(16'sd0, 16'sd0, 1'b1);
  endtask

  // zero and oversized register values, zero range
  task automatic test_clamps();
    set_config(0, 0, 0, 0, 0);          // lengths and box used as one, every sample a pixel
    for (int i = 0; i < 12; i++) send_sample(rand_part(), rand_part(), i[0]);
    set_config(4095, 8191, 31, -100, 4095);  // maximum sizes, box used as 16
    for (int i = 0; i < 40; i++) send_sample(rand_part(), rand_part(), 1'b0);
    set_config(2048, 1, 1, 960, 1600);  // full width row, one row per frame
    for (int i = 0; i < 40; i++) send_sample(rand_part(), rand_part(), 1'b1);
  endtask

  // pixels at every sample while the receiver holds off: queues fill, input stalls
  task automatic test_backpressure();
    set_config(1, 1, 1, -800, 2000);
    no_gaps = 1;
    hold_tag++;
    for (int i = 0; i < 60; i++) send_sample(rand_part(), rand_part(), 1'b0);
    no_gaps = 0;
  endtask

  // register change without going back to frame start
  task automatic test_mid_frame_change();
    set_config(12, 12, 4, 0, 1000);
    for (int i = 0; i < 30; i++) send_sample(rand_part(), rand_part(), 1'b0);
    set_config(6, 4, 2, 0, 1000);
    for (int i = 0; i < 40; i++) send_sample(rand_part(), rand_part(), 1'b1);
  endtask

  // random settings, mostly small boxes and rows so that pixels are frequent
  task automatic test_random();
    int spr, rpf, bf, n;
    bit rtl;
    for (int ph = 0; ph < 10; ph++) begin
      bf  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      spr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 24);
      rpf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 20);
      set_config(spr, rpf, bf, $urandom_range(0, 4095),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(16, 4095));
      no_gaps = ($urandom_range(0, 3) == 0);
      rtl = $urandom_range(0, 1);
      n = $urandom_range(100, 135);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 40) == 0) rtl = ~rtl;
        send_sample(rand_part(), rand_part(), rtl);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    errors    = 0;
    cycles    = 0;
    hold_tag  = 0;
    burst_left = 0;
    no_gaps   = 0;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_sample_re     <= '0;
    in_sample_im     <= '0;
    in_right_to_left <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    // predictor reset values
    r_spr = 13'd2048;
    r_rpf = 13'd4096;
    r_bf  = 5'd4;
    r_min = 12'sd960;
    r_range = 12'd1600;
    foreach (box_sum[i]) box_sum[i] = '0;
    smp_idx = 0;
    band_row = 0;
    frame_row = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_odd_box();
    test_clamps();
    test_backpressure();
    test_mid_frame_change();
    test_random();

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
